>>> design/mdg_pkg.sv
// shared constants, command codes and control structs of the max density grid builder
`timescale 1ns / 1ps

package mdg_pkg;

  localparam int MAX_DIVISION  = 16;
  localparam int MAX_DIM       = 1024;
  localparam int TABLE_ENTRIES = 256;

  localparam int GRID_CELLS = MAX_DIVISION * MAX_DIVISION * MAX_DIVISION;
  localparam int COORD_W    = $clog2(MAX_DIVISION);
  localparam int CELL_W     = $clog2(GRID_CELLS);
  localparam int T_W        = 2 * COORD_W;
  localparam int POS_W      = $clog2(MAX_DIM);
  localparam int SIZE_W     = $clog2(MAX_DIM) + 1;
  localparam int DIV_W      = $clog2(MAX_DIVISION) + 1;
  localparam int NUM_W      = POS_W + DIV_W;
  localparam int CNT_W      = $clog2(NUM_W);
  localparam int DENS_W     = 8;
  localparam int ENTRY_W    = $clog2(TABLE_ENTRIES);
  localparam int WORD_W     = 32;
  localparam int CMD_W      = 2;

  localparam logic [WORD_W-1:0] DENSITY_MASK  = 32'hFF00_0000;
  localparam int                DENSITY_SHIFT = 24;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD  = 2'd0,
    CMD_VOXEL = 2'd1,
    CMD_READ  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_e;

  typedef struct packed {
    logic table_we;
    logic voxel_start;
    logic div_step;
    logic cell_a;
    logic cell_b;
    logic grid_rd_voxel;
    logic grid_wr_voxel;
    logic read_start;
    logic out_load;
    logic clear_step;
  } dp_cmd_t;

  typedef struct packed {
    logic clear_last;
  } dp_status_t;

endpackage

>>> design/max_density_grid_builder.sv
// max density grid builder top level: apb registers, controller and datapath
// load word: written to the density table on accept; the input stays ready for the next word
// voxel word: runs the 15-step restoring dividers per axis, then the two cell index
//   multiply stages and a grid read-modify-write, with in_ready_o low throughout
// read word: the cell is read into a register, then loaded to the output once it is free
// reset: a clearing pass over all 4096 cells zeroes the grid with in_ready_o low; registers writable
`timescale 1ns / 1ps

module max_density_grid_builder (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [3:0]                     paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [mdg_pkg::CMD_W-1:0]      command_i,
  input  logic [mdg_pkg::ENTRY_W-1:0]    entry_index_i,
  input  logic [mdg_pkg::WORD_W-1:0]     table_word_i,
  input  logic [mdg_pkg::ENTRY_W-1:0]    voxel_value_i,
  input  logic [mdg_pkg::CELL_W-1:0]     cell_index_i,
  input  logic                           clear_after_read_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [mdg_pkg::CELL_W-1:0]     cell_number_o,
  output logic [mdg_pkg::DENS_W-1:0]     cell_max_o
);

  localparam logic [1:0] REG_VOL_WIDTH     = 2'd0;
  localparam logic [1:0] REG_VOL_HEIGHT    = 2'd1;
  localparam logic [1:0] REG_VOL_DEPTH     = 2'd2;
  localparam logic [1:0] REG_GRID_DIVISION = 2'd3;

  logic [mdg_pkg::SIZE_W-1:0] vol_width_q, vol_height_q, vol_depth_q;
  logic [mdg_pkg::DIV_W-1:0]  grid_division_q;
  logic                       cfg_we;
  logic [1:0]                 cfg_idx;

  mdg_pkg::dp_cmd_t    dp_cmd;
  mdg_pkg::dp_status_t dp_status;

  assign pready  = 1'b1;
  assign cfg_idx = paddr[3:2];
  assign cfg_we  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vol_width_q     <= mdg_pkg::SIZE_W'(256);
      vol_height_q    <= mdg_pkg::SIZE_W'(256);
      vol_depth_q     <= mdg_pkg::SIZE_W'(256);
      grid_division_q <= mdg_pkg::DIV_W'(16);
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_VOL_WIDTH:     vol_width_q     <= pwdata[mdg_pkg::SIZE_W-1:0];
        REG_VOL_HEIGHT:    vol_height_q    <= pwdata[mdg_pkg::SIZE_W-1:0];
        REG_VOL_DEPTH:     vol_depth_q     <= pwdata[mdg_pkg::SIZE_W-1:0];
        REG_GRID_DIVISION: grid_division_q <= pwdata[mdg_pkg::DIV_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_VOL_WIDTH:     prdata = 32'(vol_width_q);
      REG_VOL_HEIGHT:    prdata = 32'(vol_height_q);
      REG_VOL_DEPTH:     prdata = 32'(vol_depth_q);
      REG_GRID_DIVISION: prdata = 32'(grid_division_q);
      default:           prdata = '0;
    endcase
  end

  mdg_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .command_i   (command_i),
    .out_ready_i (out_ready_i),
    .status_i    (dp_status),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .cmd_o       (dp_cmd)
  );

  mdg_datapath u_datapath (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (dp_cmd),
    .status_o           (dp_status),
    .vol_width_i        (vol_width_q),
    .vol_height_i       (vol_height_q),
    .vol_depth_i        (vol_depth_q),
    .grid_division_i    (grid_division_q),
    .entry_index_i      (entry_index_i),
    .table_word_i       (table_word_i),
    .voxel_value_i      (voxel_value_i),
    .cell_index_i       (cell_index_i),
    .clear_after_read_i (clear_after_read_i),
    .cell_number_o      (cell_number_o),
    .cell_max_o         (cell_max_o)
  );

`ifndef NO_ASSERTIONS
  // a voxel or read word blocks the input for at least the next cycle
  a_busy_after_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o &&
    (command_i == mdg_pkg::CMD_VOXEL || command_i == mdg_pkg::CMD_READ)
    |=> !in_ready_o)
    else $error("input ready right after a voxel or read word");

  // a new result is loaded only while the input side is busy with a read
  a_result_from_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> !$past(in_ready_o))
    else $error("result appeared without a read in progress");

  // no words accepted during the clearing pass
  a_no_accept_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dp_cmd.clear_step |-> !in_ready_o)
    else $error("input ready during grid clearing pass");
`endif

endmodule

>>> design/mdg_axis_div.sv
// restoring divider, one quotient bit per step, for one axis cell coordinate
`timescale 1ns / 1ps

module mdg_axis_div (
  input  logic                        clk_i,
  input  logic                        start_i,
  input  logic                        step_i,
  input  logic [mdg_pkg::NUM_W-1:0]   num_i,
  input  logic [mdg_pkg::SIZE_W-1:0]  den_i,
  output logic [mdg_pkg::NUM_W-1:0]   quo_o
);

  logic [mdg_pkg::NUM_W-1:0]  num_q, num_d;
  logic [mdg_pkg::NUM_W-1:0]  quo_q, quo_d;
  logic [mdg_pkg::SIZE_W-1:0] rem_q, rem_d;
  logic [mdg_pkg::SIZE_W-1:0] den_q;
  logic [mdg_pkg::SIZE_W:0]   trial;
  logic                       fits;

  assign trial = {rem_q, num_q[mdg_pkg::NUM_W-1]};
  assign fits  = trial >= {1'b0, den_q};

  always_comb begin
    num_d = {num_q[mdg_pkg::NUM_W-2:0], 1'b0};
    quo_d = {quo_q[mdg_pkg::NUM_W-2:0], fits};
    if (fits) begin
      rem_d = mdg_pkg::SIZE_W'(trial - {1'b0, den_q});
    end else begin
      rem_d = trial[mdg_pkg::SIZE_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= num_i;
      den_q <= den_i;
      rem_q <= '0;
      quo_q <= '0;
    end else if (step_i) begin
      num_q <= num_d;
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign quo_o = quo_q;

endmodule

>>> design/mdg_datapath.sv
// datapath: density table, raster counters, cell dividers, cell index and grid memory
`timescale 1ns / 1ps

module mdg_datapath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  mdg_pkg::dp_cmd_t              cmd_i,
  output mdg_pkg::dp_status_t           status_o,
  input  logic [mdg_pkg::SIZE_W-1:0]    vol_width_i,
  input  logic [mdg_pkg::SIZE_W-1:0]    vol_height_i,
  input  logic [mdg_pkg::SIZE_W-1:0]    vol_depth_i,
  input  logic [mdg_pkg::DIV_W-1:0]     grid_division_i,
  input  logic [mdg_pkg::ENTRY_W-1:0]   entry_index_i,
  input  logic [mdg_pkg::WORD_W-1:0]    table_word_i,
  input  logic [mdg_pkg::ENTRY_W-1:0]   voxel_value_i,
  input  logic [mdg_pkg::CELL_W-1:0]    cell_index_i,
  input  logic                          clear_after_read_i,
  output logic [mdg_pkg::CELL_W-1:0]    cell_number_o,
  output logic [mdg_pkg::DENS_W-1:0]    cell_max_o
);

  function automatic logic [mdg_pkg::SIZE_W-1:0] clamp_size(
    input logic [mdg_pkg::SIZE_W-1:0] v
  );
    logic [mdg_pkg::SIZE_W-1:0] r;
    if (v == '0) begin
      r = mdg_pkg::SIZE_W'(1);
    end else if (v > mdg_pkg::SIZE_W'(mdg_pkg::MAX_DIM)) begin
      r = mdg_pkg::SIZE_W'(mdg_pkg::MAX_DIM);
    end else begin
      r = v;
    end
    return r;
  endfunction

  function automatic logic [mdg_pkg::COORD_W-1:0] clamp_coord(
    input logic [mdg_pkg::NUM_W-1:0] q,
    input logic [mdg_pkg::DIV_W-1:0] div
  );
    logic [mdg_pkg::COORD_W-1:0] r;
    if (q >= mdg_pkg::NUM_W'(div)) begin
      r = mdg_pkg::COORD_W'(div - mdg_pkg::DIV_W'(1));
    end else begin
      r = q[mdg_pkg::COORD_W-1:0];
    end
    return r;
  endfunction

  logic [mdg_pkg::SIZE_W-1:0] size_w, size_h, size_d;
  logic [mdg_pkg::DIV_W-1:0]  div_c;

  logic [mdg_pkg::POS_W-1:0]  pos_x_q, pos_y_q, pos_z_q;
  logic [mdg_pkg::POS_W-1:0]  pos_x_d, pos_y_d, pos_z_d;
  logic [mdg_pkg::SIZE_W-1:0] inc_x, inc_y, inc_z;

  logic [mdg_pkg::NUM_W-1:0]  num_x, num_y, num_z;
  logic [mdg_pkg::NUM_W-1:0]  quo_x, quo_y, quo_z;
  logic [mdg_pkg::COORD_W-1:0] cx, cy, cz;

  logic [mdg_pkg::COORD_W-1:0] cx_q;
  logic [mdg_pkg::T_W-1:0]     t_q;
  logic [mdg_pkg::CELL_W-1:0]  cell_q;

  logic [mdg_pkg::DENS_W-1:0] density_table [mdg_pkg::TABLE_ENTRIES];
  logic [mdg_pkg::DENS_W-1:0] dens_q;
  logic [mdg_pkg::DENS_W-1:0] load_dens;

  logic [mdg_pkg::DENS_W-1:0] max_grid [mdg_pkg::GRID_CELLS];
  logic [mdg_pkg::DENS_W-1:0] grid_rd_q;
  logic                       grid_re, grid_we;
  logic [mdg_pkg::CELL_W-1:0] grid_raddr, grid_waddr;
  logic [mdg_pkg::DENS_W-1:0] grid_wdata;

  logic [mdg_pkg::CELL_W-1:0] clr_addr_q;
  logic [mdg_pkg::CELL_W-1:0] rd_cell_q;
  logic                       rd_clear_q;
  logic [mdg_pkg::CELL_W-1:0] cell_number_q;
  logic [mdg_pkg::DENS_W-1:0] cell_max_q;

  assign size_w = clamp_size(vol_width_i);
  assign size_h = clamp_size(vol_height_i);
  assign size_d = clamp_size(vol_depth_i);

  always_comb begin
    if (grid_division_i == '0) begin
      div_c = mdg_pkg::DIV_W'(1);
    end else if (grid_division_i > mdg_pkg::DIV_W'(mdg_pkg::MAX_DIVISION)) begin
      div_c = mdg_pkg::DIV_W'(mdg_pkg::MAX_DIVISION);
    end else begin
      div_c = grid_division_i;
    end
  end

  // raster counters, x fastest, wrap when at or past the size
  assign inc_x = mdg_pkg::SIZE_W'(pos_x_q) + mdg_pkg::SIZE_W'(1);
  assign inc_y = mdg_pkg::SIZE_W'(pos_y_q) + mdg_pkg::SIZE_W'(1);
  assign inc_z = mdg_pkg::SIZE_W'(pos_z_q) + mdg_pkg::SIZE_W'(1);

  always_comb begin
    pos_x_d = pos_x_q;
    pos_y_d = pos_y_q;
    pos_z_d = pos_z_q;
    if (inc_x >= size_w) begin
      pos_x_d = '0;
      if (inc_y >= size_h) begin
        pos_y_d = '0;
        pos_z_d = (inc_z >= size_d) ? '0 : inc_z[mdg_pkg::POS_W-1:0];
      end else begin
        pos_y_d = inc_y[mdg_pkg::POS_W-1:0];
      end
    end else begin
      pos_x_d = inc_x[mdg_pkg::POS_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_x_q <= '0;
      pos_y_q <= '0;
      pos_z_q <= '0;
    end else if (cmd_i.voxel_start) begin
      pos_x_q <= pos_x_d;
      pos_y_q <= pos_y_d;
      pos_z_q <= pos_z_d;
    end
  end

  // numerators pos*div, divided by the axis size
  assign num_x = mdg_pkg::NUM_W'(pos_x_q) * mdg_pkg::NUM_W'(div_c);
  assign num_y = mdg_pkg::NUM_W'(pos_y_q) * mdg_pkg::NUM_W'(div_c);
  assign num_z = mdg_pkg::NUM_W'(pos_z_q) * mdg_pkg::NUM_W'(div_c);

  mdg_axis_div u_div_x (
    .clk_i   (clk_i),
    .start_i (cmd_i.voxel_start),
    .step_i  (cmd_i.div_step),
    .num_i   (num_x),
    .den_i   (size_w),
    .quo_o   (quo_x)
  );

  mdg_axis_div u_div_y (
    .clk_i   (clk_i),
    .start_i (cmd_i.voxel_start),
    .step_i  (cmd_i.div_step),
    .num_i   (num_y),
    .den_i   (size_h),
    .quo_o   (quo_y)
  );

  mdg_axis_div u_div_z (
    .clk_i   (clk_i),
    .start_i (cmd_i.voxel_start),
    .step_i  (cmd_i.div_step),
    .num_i   (num_z),
    .den_i   (size_d),
    .quo_o   (quo_z)
  );

  assign cx = clamp_coord(quo_x, div_c);
  assign cy = clamp_coord(quo_y, div_c);
  assign cz = clamp_coord(quo_z, div_c);

  // cell = cx + div*(cy + div*cz), one multiply per stage
  always_ff @(posedge clk_i) begin
    if (cmd_i.cell_a) begin
      cx_q <= cx;
      t_q  <= mdg_pkg::T_W'(cy) + mdg_pkg::T_W'(div_c) * mdg_pkg::T_W'(cz);
    end
    if (cmd_i.cell_b) begin
      cell_q <= mdg_pkg::CELL_W'(cx_q) + mdg_pkg::CELL_W'(div_c) * mdg_pkg::CELL_W'(t_q);
    end
  end

  // density table
  assign load_dens = mdg_pkg::DENS_W'((table_word_i & mdg_pkg::DENSITY_MASK)
                                      >> mdg_pkg::DENSITY_SHIFT);

  always_ff @(posedge clk_i) begin
    if (cmd_i.table_we) begin
      density_table[entry_index_i] <= load_dens;
    end
    if (cmd_i.voxel_start) begin
      dens_q <= density_table[voxel_value_i];
    end
  end

  // read word capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.read_start) begin
      rd_cell_q  <= cell_index_i;
      rd_clear_q <= clear_after_read_i;
    end
  end

  // grid memory port control
  always_comb begin
    grid_re    = cmd_i.grid_rd_voxel || cmd_i.read_start;
    grid_raddr = cmd_i.read_start ? cell_index_i : cell_q;
    grid_we    = 1'b0;
    grid_waddr = cell_q;
    grid_wdata = dens_q;
    if (cmd_i.clear_step) begin
      grid_we    = 1'b1;
      grid_waddr = clr_addr_q;
      grid_wdata = '0;
    end else if (cmd_i.out_load) begin
      grid_we    = rd_clear_q;
      grid_waddr = rd_cell_q;
      grid_wdata = '0;
    end else if (cmd_i.grid_wr_voxel) begin
      grid_we    = dens_q > grid_rd_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (grid_we) begin
      max_grid[grid_waddr] <= grid_wdata;
    end
    if (grid_re) begin
      grid_rd_q <= max_grid[grid_raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_addr_q <= '0;
    end else if (cmd_i.clear_step) begin
      clr_addr_q <= clr_addr_q + mdg_pkg::CELL_W'(1);
    end
  end

  assign status_o.clear_last = (clr_addr_q == mdg_pkg::CELL_W'(mdg_pkg::GRID_CELLS - 1));

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      cell_number_q <= rd_cell_q;
      cell_max_q    <= grid_rd_q;
    end
  end

  assign cell_number_o = cell_number_q;
  assign cell_max_o    = cell_max_q;

endmodule

>>> design/mdg_ctrl.sv
// controller: sequences clearing pass, table loads, voxel updates and cell reads
`timescale 1ns / 1ps

module mdg_ctrl (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  input  logic [mdg_pkg::CMD_W-1:0]   command_i,
  input  logic                        out_ready_i,
  input  mdg_pkg::dp_status_t         status_i,
  output logic                        in_ready_o,
  output logic                        out_valid_o,
  output mdg_pkg::dp_cmd_t            cmd_o
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DIV,
    S_CELL_A,
    S_CELL_B,
    S_GRID_RD,
    S_GRID_WR,
    S_RD_WAIT
  } state_e;

  state_e                    state_q, state_d;
  logic [mdg_pkg::CNT_W-1:0] cnt_q, cnt_d;
  logic                      in_ready_q;
  logic                      out_valid_q, out_valid_d;
  logic                      accept;

  assign accept = in_valid_i && in_ready_q;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    case (state_q)
      S_CLEAR: begin
        cmd_o.clear_step = 1'b1;
        if (status_i.clear_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          case (mdg_pkg::cmd_e'(command_i))
            mdg_pkg::CMD_LOAD: begin
              cmd_o.table_we = 1'b1;
            end
            mdg_pkg::CMD_VOXEL: begin
              cmd_o.voxel_start = 1'b1;
              cnt_d             = '0;
              state_d           = S_DIV;
            end
            mdg_pkg::CMD_READ: begin
              cmd_o.read_start = 1'b1;
              state_d          = S_RD_WAIT;
            end
            default: ;
          endcase
        end
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + mdg_pkg::CNT_W'(1);
        if (cnt_q == mdg_pkg::CNT_W'(mdg_pkg::NUM_W - 1)) begin
          state_d = S_CELL_A;
        end
      end
      S_CELL_A: begin
        cmd_o.cell_a = 1'b1;
        state_d      = S_CELL_B;
      end
      S_CELL_B: begin
        cmd_o.cell_b = 1'b1;
        state_d      = S_GRID_RD;
      end
      S_GRID_RD: begin
        cmd_o.grid_rd_voxel = 1'b1;
        state_d             = S_GRID_WR;
      end
      S_GRID_WR: begin
        cmd_o.grid_wr_voxel = 1'b1;
        state_d             = S_IDLE;
      end
      S_RD_WAIT: begin
        // wait for a free output slot, read data holds meanwhile
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      cnt_q       <= '0;
      in_ready_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      in_ready_q  <= (state_d == S_IDLE);
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = in_ready_q;
  assign out_valid_o = out_valid_q;

endmodule
